FILE: rtl/core/calendar_second_counter_assert.svh
// assertion macros shared by the calendar second counter rtl
`ifndef CALENDAR_SECOND_COUNTER_ASSERT_SVH
`define CALENDAR_SECOND_COUNTER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cscnt_pkg.sv
// types, constants and calendar helpers for the calendar second counter
`timescale 1ns / 1ps
`default_nettype none

package cscnt_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW = 6;
  localparam int unsigned SecW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 14;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } time_t;

  localparam int unsigned TimeW = $bits(time_t);

  typedef enum logic {
    OpAdvance = 1'b0,
    OpLoad    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OrdLess    = 2'd0,
    OrdEqual   = 2'd1,
    OrdGreater = 2'd2
  } order_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRefYear   = 3'd0,
    CfgRefMonth  = 3'd1,
    CfgRefDay    = 3'd2,
    CfgRefHour   = 3'd3,
    CfgRefMinute = 3'd4,
    CfgRefSecond = 3'd5
  } cfg_idx_e;

  localparam logic [SecW-1:0]   SecLast   = 6'd59;
  localparam logic [MinW-1:0]   MinLast   = 6'd59;
  localparam logic [HourW-1:0]  HourLast  = 5'd23;
  localparam logic [MonthW-1:0] MonthLast = 4'd12;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [YearW-1:0]  YearLast  = 14'd9999;

  localparam logic [DayW-1:0] DaysUnknown = 5'd31;
  localparam logic [DayW-1:0] DaysFebLeap = 5'd29;

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // divisibility by 25: multiply by the inverse of 25 mod 2^14, then range check
  localparam logic [YearW-1:0] Inv25    = 14'd7209;
  localparam logic [YearW-1:0] Div25Max = 14'd655;

  localparam time_t TimeReset = '{
    year: '0, month: 4'd1, day: 5'd1, hour: '0, minute: '0, second: '0
  };

  // gregorian rule: by 4 and not by 100, or by 400 (100 = 4*25, 400 = 16*25)
  function automatic logic is_leap(logic [YearW-1:0] y);
    logic [2*YearW-1:0] prod;
    logic div25;
    prod  = (2*YearW)'(y) * (2*YearW)'(Inv25);
    div25 = (prod[YearW-1:0] <= Div25Max);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] days_in(logic [YearW-1:0] y,
                                               logic [MonthW-1:0] m);
    logic [DayW-1:0] d;
    if ((m == '0) || (m > MonthLast)) begin
      d = DaysUnknown;
    end else if ((m == MonthFeb) && is_leap(y)) begin
      d = DaysFebLeap;
    end else begin
      d = MonthLen[m - 4'd1];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cscnt_next.sv
// next-time logic: one-second advance with cascaded rollover, or load
`timescale 1ns / 1ps
`default_nettype none

module cscnt_next
  import cscnt_pkg::*;
(
  input  time_t cur_i,
  input  op_e   op_i,
  input  time_t load_i,
  output time_t nxt_o
);

  logic [DayW-1:0] dim;

  assign dim = days_in(cur_i.year, cur_i.month);

  always_comb begin
    nxt_o = cur_i;
    if (op_i == OpLoad) begin
      nxt_o = load_i;
    end else if (cur_i.second < SecLast) begin
      nxt_o.second = cur_i.second + 6'd1;
    end else begin
      nxt_o.second = '0;
      if (cur_i.minute < MinLast) begin
        nxt_o.minute = cur_i.minute + 6'd1;
      end else begin
        nxt_o.minute = '0;
        if (cur_i.hour < HourLast) begin
          nxt_o.hour = cur_i.hour + 5'd1;
        end else begin
          nxt_o.hour = '0;
          if (cur_i.day < dim) begin
            nxt_o.day = cur_i.day + 5'd1;
          end else begin
            nxt_o.day = 5'd1;
            // month 0 steps to 1 without a year carry
            if (cur_i.month == '0) begin
              nxt_o.month = 4'd1;
            end else if (cur_i.month < MonthLast) begin
              nxt_o.month = cur_i.month + 4'd1;
            end else begin
              nxt_o.month = 4'd1;
              nxt_o.year  = (cur_i.year >= YearLast) ? '0 : cur_i.year + 14'd1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cscnt_skid.sv
// two-entry output buffer: output register plus one skid register
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_second_counter_assert.svh"

module cscnt_skid
  import cscnt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  time_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output time_t out_data_o
);

  logic  out_valid_q, skid_valid_q;
  time_t out_q, skid_q;
  logic  push, pop;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CSC_ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full while output empty")

endmodule

`default_nettype wire

FILE: rtl/core/calendar_second_counter.sv
// top level of the calendar second counter with reference-time ordering
`timescale 1ns / 1ps
`default_nettype none

// calendar second counter: keeps year, month, day, hour, minute and second.
// an advance beat (opcode 0) adds one second with cascaded rollover through
// minute, hour, day (month length, 29-day february in gregorian leap years),
// month and year (9999 wraps to 0); a load beat (opcode 1) sets all six
// fields as given, unchecked. every input beat yields exactly one output beat
// with the time after that beat and its order against the reference time in
// the config registers: 0 earlier, 1 equal, 2 later. one input beat per cycle
// is taken while the output buffer has room; each result is registered there. the
// rollover cascade sits between the time register and the output buffer, and
// a two-entry output buffer lets input keep flowing for one beat while the
// output side stalls. the order is compared on the buffered time against the
// reference registers, so reference writes are to be made only while idle.
// config: write cfg_we_i with cfg_idx_i 0..5 (year, month, day, hour, minute,
// second); other indexes are ignored. no clearing pass after reset.

`include "calendar_second_counter_assert.svh"

module calendar_second_counter
  import cscnt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [YearW-1:0]     load_year_i,
  input  logic [MonthW-1:0]    load_month_i,
  input  logic [DayW-1:0]      load_day_i,
  input  logic [HourW-1:0]     load_hour_i,
  input  logic [MinW-1:0]      load_minute_i,
  input  logic [SecW-1:0]      load_second_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [YearW-1:0]     out_year_o,
  output logic [MonthW-1:0]    out_month_o,
  output logic [DayW-1:0]      out_day_o,
  output logic [HourW-1:0]     out_hour_o,
  output logic [MinW-1:0]      out_minute_o,
  output logic [SecW-1:0]      out_second_o,
  output logic [1:0]           order_o
);

  time_t  cur_q;     // running time
  time_t  ref_q;     // reference time from config
  time_t  load_time;
  time_t  nxt_time;
  time_t  out_time;
  logic   accept;
  order_e order;

  // ---------------------------------------------------------------------------
  // reference registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= TimeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRefYear:   ref_q.year   <= cfg_wdata_i[YearW-1:0];
        CfgRefMonth:  ref_q.month  <= cfg_wdata_i[MonthW-1:0];
        CfgRefDay:    ref_q.day    <= cfg_wdata_i[DayW-1:0];
        CfgRefHour:   ref_q.hour   <= cfg_wdata_i[HourW-1:0];
        CfgRefMinute: ref_q.minute <= cfg_wdata_i[MinW-1:0];
        CfgRefSecond: ref_q.second <= cfg_wdata_i[SecW-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // time register and next-time logic
  // ---------------------------------------------------------------------------
  assign load_time = '{
    year:   load_year_i,
    month:  load_month_i,
    day:    load_day_i,
    hour:   load_hour_i,
    minute: load_minute_i,
    second: load_second_i
  };

  assign accept = in_valid_i && in_ready_o;

  cscnt_next u_next (
    .cur_i  (cur_q),
    .op_i   (op_e'(opcode_i)),
    .load_i (load_time),
    .nxt_o  (nxt_time)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= TimeReset;
    end else if (accept) begin
      cur_q <= nxt_time;
    end
  end

  // ---------------------------------------------------------------------------
  // output buffer; the new time is written here at the same edge it is stored
  // ---------------------------------------------------------------------------
  cscnt_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (nxt_time),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_time)
  );

  // lexicographic order equals an unsigned compare of the packed fields
  always_comb begin
    if (TimeW'(out_time) < TimeW'(ref_q)) begin
      order = OrdLess;
    end else if (out_time == ref_q) begin
      order = OrdEqual;
    end else begin
      order = OrdGreater;
    end
  end

  assign out_year_o   = out_time.year;
  assign out_month_o  = out_time.month;
  assign out_day_o    = out_time.day;
  assign out_hour_o   = out_time.hour;
  assign out_minute_o = out_time.minute;
  assign out_second_o = out_time.second;
  assign order_o      = order;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CSC_ASSERT_NXT(a_load_takes, clk_i, rst_ni, accept && (opcode_i == OpLoad), (cur_q.year == $past(load_year_i)) && (cur_q.second == $past(load_second_i)), "load beat not stored")
  `CSC_ASSERT_NXT(a_tick_sec, clk_i, rst_ni, accept && (opcode_i == OpAdvance) && (cur_q.second < SecLast), (cur_q.second == $past(cur_q.second) + 6'd1) && (cur_q.minute == $past(cur_q.minute)), "plain tick did not step the second alone")

endmodule

`default_nettype wire
